// ===== design/round_robin_run_queue_top_defines.svh =====
`ifndef ROUND_ROBIN_RUN_QUEUE_TOP_DEFINES_SVH
`define ROUND_ROBIN_RUN_QUEUE_TOP_DEFINES_SVH

// implication checked in the same cycle
`define RRRQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked from the next cycle on
`define RRRQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rrrq_pkg.sv =====
`default_nettype none

package rrrq_pkg;

   localparam int ID_W       = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_PICK = 1'b1;

   localparam logic REG_IDLE_THREAD = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   typedef struct packed {
      logic next_we;
      logic flag_we;
      logic flag_val;
   } node_wr_type;

endpackage

`default_nettype wire

// ===== design/round_robin_run_queue_top.sv =====
`default_nettype none
// Round-robin run queue of thread slots, kept as a circular doubly linked ring.
// Input channel (req_*): kind 0 sets the runnable state of req_thread_id,
// kind 1 picks the head thread and rotates the head to its successor.
// Result channel (rsp_*): one transfer per pick, none for set-state items.
// An empty ring returns the idle_thread register with rsp_was_idle set.
// Configuration: APB-style port, idle_thread at byte address 0.
// Timing: every item takes its read cycle at the transfer edge, then evaluates.
// A pick waits in ST_EVAL until the result register is free, then writes its
// result there; that register drives rsp_valid, rsp_picked_thread and rsp_was_idle.
// A set-state item that links a thread into a non-empty ring or unlinks one also
// passes through ST_FIN, since each link memory has a single write port.
// After reset the runnable flags are cleared one slot per cycle, and req_ready
// stays low until every slot is clear.
// A stalled receiver holds the result register; further set-state items are
// still taken, and a following pick waits until the result is taken.
module round_robin_run_queue_top #(
   parameter int THREAD_SLOTS = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_kind,
   input  wire  [rrrq_pkg::ID_W-1:0]           req_thread_id,
   input  wire                                 req_runnable,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [rrrq_pkg::ID_W-1:0]           rsp_picked_thread,
   output logic                                rsp_was_idle,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [rrrq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [rrrq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rrrq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import rrrq_pkg::*;

   localparam int SLOT_W = $clog2(THREAD_SLOTS);

   logic [ID_W-1:0]   idle_thread;
   logic              rd_en;
   logic [SLOT_W-1:0] node_rd_addr;
   logic              node_rd_flag;
   logic [SLOT_W-1:0] node_rd_next;
   node_wr_type       node_wr;
   logic [SLOT_W-1:0] node_wr_addr;
   logic [SLOT_W-1:0] node_wr_next;
   logic [SLOT_W-1:0] prev_rd_addr_a;
   logic [SLOT_W-1:0] prev_rd_addr_b;
   logic [SLOT_W-1:0] prev_rd_data_a;
   logic [SLOT_W-1:0] prev_rd_data_b;
   logic              prev_we;
   logic [SLOT_W-1:0] prev_wr_addr;
   logic [SLOT_W-1:0] prev_wr_data;

   rrrq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .idle_thread (idle_thread)
   );

   rrrq_node_ram #(
      .THREAD_SLOTS (THREAD_SLOTS),
      .SLOT_W       (SLOT_W)
   ) u_node_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (node_rd_addr),
      .rd_flag (node_rd_flag),
      .rd_next (node_rd_next),
      .wr      (node_wr),
      .wr_addr (node_wr_addr),
      .wr_next (node_wr_next)
   );

   rrrq_prev_ram #(
      .THREAD_SLOTS (THREAD_SLOTS),
      .SLOT_W       (SLOT_W)
   ) u_prev_ram (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr_a (prev_rd_addr_a),
      .rd_addr_b (prev_rd_addr_b),
      .rd_data_a (prev_rd_data_a),
      .rd_data_b (prev_rd_data_b),
      .wr_en     (prev_we),
      .wr_addr   (prev_wr_addr),
      .wr_data   (prev_wr_data)
   );

   rrrq_ctrl #(
      .THREAD_SLOTS (THREAD_SLOTS),
      .SLOT_W       (SLOT_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_thread_id     (req_thread_id),
      .req_runnable      (req_runnable),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_picked_thread (rsp_picked_thread),
      .rsp_was_idle      (rsp_was_idle),
      .idle_thread       (idle_thread),
      .rd_en             (rd_en),
      .node_rd_addr      (node_rd_addr),
      .node_rd_flag      (node_rd_flag),
      .node_rd_next      (node_rd_next),
      .node_wr           (node_wr),
      .node_wr_addr      (node_wr_addr),
      .node_wr_next      (node_wr_next),
      .prev_rd_addr_a    (prev_rd_addr_a),
      .prev_rd_addr_b    (prev_rd_addr_b),
      .prev_rd_data_a    (prev_rd_data_a),
      .prev_rd_data_b    (prev_rd_data_b),
      .prev_we           (prev_we),
      .prev_wr_addr      (prev_wr_addr),
      .prev_wr_data      (prev_wr_data)
   );

endmodule

`default_nettype wire

// ===== design/rrrq_node_ram.sv =====
`default_nettype none

module rrrq_node_ram #(
   parameter int THREAD_SLOTS = 64,
   parameter int SLOT_W       = 6
) (
   input  wire                      clock,
   input  wire                      rd_en,
   input  wire  [SLOT_W-1:0]        rd_addr,
   output logic                     rd_flag,
   output logic [SLOT_W-1:0]        rd_next,
   input  wire  rrrq_pkg::node_wr_type wr,
   input  wire  [SLOT_W-1:0]        wr_addr,
   input  wire  [SLOT_W-1:0]        wr_next
);
   import rrrq_pkg::*;

   // runnable flag on top, successor link below, with per-field write enables
   logic [SLOT_W:0] mem_ff [THREAD_SLOTS];
   logic [SLOT_W:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.next_we) begin
         mem_ff[wr_addr][SLOT_W-1:0] <= wr_next;
      end
      if (wr.flag_we) begin
         mem_ff[wr_addr][SLOT_W] <= wr.flag_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_flag = rd_data_ff[SLOT_W];
   assign rd_next = rd_data_ff[SLOT_W-1:0];

endmodule

`default_nettype wire

// ===== design/rrrq_prev_ram.sv =====
`default_nettype none

module rrrq_prev_ram #(
   parameter int THREAD_SLOTS = 64,
   parameter int SLOT_W       = 6
) (
   input  wire                clock,
   input  wire                rd_en,
   input  wire  [SLOT_W-1:0]  rd_addr_a,
   input  wire  [SLOT_W-1:0]  rd_addr_b,
   output logic [SLOT_W-1:0]  rd_data_a,
   output logic [SLOT_W-1:0]  rd_data_b,
   input  wire                wr_en,
   input  wire  [SLOT_W-1:0]  wr_addr,
   input  wire  [SLOT_W-1:0]  wr_data
);
   logic [SLOT_W-1:0] mem_ff [THREAD_SLOTS];
   logic [SLOT_W-1:0] rd_a_ff;
   logic [SLOT_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== design/rrrq_csr.sv =====
`default_nettype none

module rrrq_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [rrrq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [rrrq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rrrq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [rrrq_pkg::ID_W-1:0]           idle_thread
);
   import rrrq_pkg::*;

   logic          reg_sel;
   logic [ID_W-1:0] idle_thread_ff;

   assign reg_sel = (paddr[CSR_ADDR_W-1] == REG_IDLE_THREAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_thread_ff <= '0;
      end else if (psel && penable && pwrite && reg_sel) begin
         idle_thread_ff <= pwdata[ID_W-1:0];
      end
   end

   assign prdata      = (psel && reg_sel) ? CSR_DATA_W'(idle_thread_ff) : '0;
   assign pready      = 1'b1;
   assign idle_thread = idle_thread_ff;

endmodule

`default_nettype wire

// ===== design/rrrq_ctrl.sv =====
`default_nettype none

module rrrq_ctrl #(
   parameter int THREAD_SLOTS = 64,
   parameter int SLOT_W       = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_kind,
   input  wire  [rrrq_pkg::ID_W-1:0]    req_thread_id,
   input  wire                          req_runnable,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [rrrq_pkg::ID_W-1:0]    rsp_picked_thread,
   output logic                         rsp_was_idle,
   input  wire  [rrrq_pkg::ID_W-1:0]    idle_thread,
   output logic                         rd_en,
   output logic [SLOT_W-1:0]            node_rd_addr,
   input  wire                          node_rd_flag,
   input  wire  [SLOT_W-1:0]            node_rd_next,
   output rrrq_pkg::node_wr_type        node_wr,
   output logic [SLOT_W-1:0]            node_wr_addr,
   output logic [SLOT_W-1:0]            node_wr_next,
   output logic [SLOT_W-1:0]            prev_rd_addr_a,
   output logic [SLOT_W-1:0]            prev_rd_addr_b,
   input  wire  [SLOT_W-1:0]            prev_rd_data_a,
   input  wire  [SLOT_W-1:0]            prev_rd_data_b,
   output logic                         prev_we,
   output logic [SLOT_W-1:0]            prev_wr_addr,
   output logic [SLOT_W-1:0]            prev_wr_data
);
   import rrrq_pkg::*;

   localparam logic [SLOT_W-1:0] CLR_LAST = SLOT_W'(THREAD_SLOTS - 1);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] clr_idx_ff, clr_idx_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic              nonempty_ff, nonempty_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_thread_ff, rsp_thread_in;
   logic              rsp_idle_ff, rsp_idle_in;
   logic              kind_ff;
   logic [SLOT_W-1:0] tid_ff;
   logic              want_ff;
   logic              inrange_ff;

   logic              accept;
   logic              out_free;
   logic [SLOT_W-1:0] tid_slot;
   logic              tid_in_range;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign tid_slot     = SLOT_W'(req_thread_id);
   assign tid_in_range = 32'(req_thread_id) < 32'(THREAD_SLOTS);

   // reads are issued in the transfer cycle
   assign rd_en          = accept;
   assign node_rd_addr   = (req_kind == KIND_PICK) ? head_ff : tid_slot;
   assign prev_rd_addr_a = tid_slot;
   assign prev_rd_addr_b = head_ff;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      head_in       = head_ff;
      nonempty_in   = nonempty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_thread_in = rsp_thread_ff;
      rsp_idle_in   = rsp_idle_ff;
      node_wr       = '0;
      node_wr_addr  = tid_ff;
      node_wr_next  = head_ff;
      prev_we       = 1'b0;
      prev_wr_addr  = tid_ff;
      prev_wr_data  = tid_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            node_wr.flag_we = 1'b1;
            node_wr_addr    = clr_idx_ff;
            if (clr_idx_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (kind_ff == KIND_PICK) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_thread_in = nonempty_ff ? ID_W'(head_ff) : idle_thread;
                  rsp_idle_in   = !nonempty_ff;
                  if (nonempty_ff) begin
                     head_in = node_rd_next;
                  end
                  state_in = ST_IDLE;
               end
            end else if (!inrange_ff || (node_rd_flag == want_ff)) begin
               state_in = ST_IDLE;
            end else if (want_ff) begin
               // link in before the head, or start a new ring
               node_wr.next_we  = 1'b1;
               node_wr.flag_we  = 1'b1;
               node_wr.flag_val = 1'b1;
               node_wr_addr     = tid_ff;
               node_wr_next     = nonempty_ff ? head_ff : tid_ff;
               prev_we          = 1'b1;
               prev_wr_addr     = tid_ff;
               prev_wr_data     = nonempty_ff ? prev_rd_data_b : tid_ff;
               if (nonempty_ff) begin
                  state_in = ST_FIN;
               end else begin
                  head_in     = tid_ff;
                  nonempty_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               // unlink: splice predecessor to successor
               node_wr.next_we = 1'b1;
               node_wr_addr    = prev_rd_data_a;
               node_wr_next    = node_rd_next;
               prev_we         = 1'b1;
               prev_wr_addr    = node_rd_next;
               prev_wr_data    = prev_rd_data_a;
               if (head_ff == tid_ff) begin
                  head_in = node_rd_next;
                  if (node_rd_next == tid_ff) begin
                     nonempty_in = 1'b0;
                  end
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (want_ff) begin
               node_wr.next_we = 1'b1;
               node_wr_addr    = prev_rd_data_b;
               node_wr_next    = tid_ff;
               prev_we         = 1'b1;
               prev_wr_addr    = head_ff;
               prev_wr_data    = tid_ff;
            end else begin
               node_wr.flag_we = 1'b1;
               node_wr_addr    = tid_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_thread_ff <= rsp_thread_in;
      rsp_idle_ff   <= rsp_idle_in;
      if (accept) begin
         kind_ff    <= req_kind;
         tid_ff     <= tid_slot;
         want_ff    <= req_runnable;
         inrange_ff <= tid_in_range;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_picked_thread = rsp_thread_ff;
   assign rsp_was_idle      = rsp_idle_ff;

endmodule

`default_nettype wire

// ===== design/rrrq_checker.sv =====
`default_nettype none
`include "round_robin_run_queue_top_defines.svh"

module rrrq_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           req_kind,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire  [rrrq_pkg::ID_W-1:0]     rsp_picked_thread,
   input wire                           rsp_was_idle
);
   import rrrq_pkg::*;

   logic req_xfer;
   logic pick_xfer;
   logic set_xfer;

   assign req_xfer  = req_valid && req_ready;
   assign pick_xfer = req_xfer && (req_kind == KIND_PICK);
   assign set_xfer  = req_xfer && (req_kind == KIND_SET);

   `RRRQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_picked_thread) && $stable(rsp_was_idle), "result changed while stalled")
   `RRRQ_ASSERT_NXT(a_one_at_a_time, req_xfer, !req_ready, "input taken while an item is in work")
   `RRRQ_ASSERT_IMP(a_pick_result, pick_xfer, ##2 rsp_valid, "pick gave no result")
   `RRRQ_ASSERT_NXT(a_set_silent, set_xfer && !rsp_valid, !rsp_valid ##1 !rsp_valid, "set-state item gave a result")

endmodule

bind round_robin_run_queue_top rrrq_checker u_rrrq_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
module tb;
   import rrrq_pkg::*;

   localparam int SLOTS       = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] thread_id;
      logic            runnable;
   } runq_item_t;

   typedef struct packed {
      logic [ID_W-1:0] thread;
      logic            idle;
   } pick_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_kind      = KIND_SET;
   logic [ID_W-1:0]       req_thread_id = '0;
   logic                  req_runnable  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [ID_W-1:0]       rsp_picked_thread;
   logic                  rsp_was_idle;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [CSR_DATA_W-1:0] pwdata        = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   round_robin_run_queue_top #(.THREAD_SLOTS(SLOTS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_thread_id(req_thread_id), .req_runnable(req_runnable),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_picked_thread(rsp_picked_thread), .rsp_was_idle(rsp_was_idle),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   runq_item_t   req_items_q [$];
   pick_result_t picks_expected_q [$];

   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int errors          = 0;
   int results_seen    = 0;
   int rsp_hold_left   = 0;
   int cycle_count     = 0;
   int n_sets          = 0;
   int n_picks         = 0;
   int n_idle_picks    = 0;
   int max_ring        = 0;
   int ring_size       = 0;

   // predicted run queue state
   logic [ID_W-1:0] idle_sel;
   logic [ID_W-1:0] ring_head;
   logic            ring_live;
   logic            run_flag [SLOTS];
   logic [ID_W-1:0] nxt_ln [SLOTS];
   logic [ID_W-1:0] prv_ln [SLOTS];

   // generator's own view of the runnable flags
   bit gen_flag [SLOTS];

   function automatic void ring_take_out(logic [ID_W-1:0] t);
      logic [ID_W-1:0] n, p;
      n = nxt_ln[t];
      p = prv_ln[t];
      if (ring_head == t) begin
         ring_head = n;
         if (n == t) ring_live = 1'b0;
      end
      nxt_ln[p] = n;
      prv_ln[n] = p;
      ring_size--;
   endfunction

   function automatic void ring_put_in(logic [ID_W-1:0] t);
      logic [ID_W-1:0] h, tl;
      if (!ring_live) begin
         ring_head = t;
         ring_live = 1'b1;
         nxt_ln[t] = t;
         prv_ln[t] = t;
      end else begin
         h = ring_head;
         tl = prv_ln[h];
         prv_ln[t] = tl;
         nxt_ln[t] = h;
         prv_ln[h] = t;
         nxt_ln[tl] = t;
      end
      ring_size++;
      if (ring_size > max_ring) max_ring = ring_size;
   endfunction

   function automatic void runq_predict(runq_item_t it);
      if (it.kind == KIND_SET) begin
         n_sets++;
         if (run_flag[it.thread_id] && !it.runnable) ring_take_out(it.thread_id);
         else if (!run_flag[it.thread_id] && it.runnable) ring_put_in(it.thread_id);
         run_flag[it.thread_id] = it.runnable;
      end else begin
         n_picks++;
         if (!ring_live) begin
            n_idle_picks++;
            picks_expected_q.push_back('{thread: idle_sel, idle: 1'b1});
         end else begin
            picks_expected_q.push_back('{thread: ring_head, idle: 1'b0});
            ring_head = nxt_ln[ring_head];
         end
      end
   endfunction

   // input channel driver
   always @(posedge clock) begin
      runq_item_t nxt_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            runq_predict({req_kind, req_thread_id, req_runnable});
         end
         if (!req_valid || req_ready) begin
            if (req_items_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt_item = req_items_q.pop_front();
               req_valid <= 1'b1;
               req_kind <= nxt_item.kind;
               req_thread_id <= nxt_item.thread_id;
               req_runnable <= nxt_item.runnable;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result channel monitor
   always @(posedge clock) begin
      pick_result_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (picks_expected_q.size() == 0) begin
               $display("%0t unexpected transfer: thread %0d idle %0b", $time,
                        rsp_picked_thread, rsp_was_idle);
               errors++;
            end else begin
               want = picks_expected_q.pop_front();
               if (rsp_picked_thread !== want.thread) begin
                  $display("%0t picked_thread expected %0d actual %0d", $time,
                           want.thread, rsp_picked_thread);
                  errors++;
               end
               if (rsp_was_idle !== want.idle) begin
                  $display("%0t was_idle expected %0b actual %0b", $time,
                           want.idle, rsp_was_idle);
                  errors++;
               end
            end
            // long receiver stall so the block backs up
            if (results_seen == 40) rsp_hold_left = 250;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_set(logic [ID_W-1:0] t, logic r);
      req_items_q.push_back('{kind: KIND_SET, thread_id: t, runnable: r});
      gen_flag[t] = r;
   endtask

   task automatic push_pick(logic [ID_W-1:0] t, logic r);
      req_items_q.push_back('{kind: KIND_PICK, thread_id: t, runnable: r});
   endtask

   task automatic csr_write(logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * int'(REG_IDLE_THREAD));
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      idle_sel = data[ID_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (req_items_q.size() != 0 || req_valid || picks_expected_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic gen_phase(int count);
      logic [ID_W-1:0] hot [8];
      int sel;
      foreach (hot[k]) hot[k] = ID_W'($urandom_range(SLOTS - 1));
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 2) begin
            // drain the ring, then pick on it empty
            for (int t = 0; t < SLOTS; t++) begin
               if (gen_flag[t]) begin
                  push_set(ID_W'(t), 1'b0);
                  if ($urandom_range(3) == 0)
                     push_pick(ID_W'($urandom), 1'($urandom_range(1)));
               end
            end
            push_pick(ID_W'($urandom), 1'($urandom_range(1)));
         end else if (sel < 37) begin
            push_pick(ID_W'($urandom), 1'($urandom_range(1)));
         end else if (sel < 85) begin
            push_set(hot[$urandom_range(7)], $urandom_range(99) < 60);
         end else begin
            push_set(ID_W'($urandom_range(SLOTS - 1)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      idle_sel = '0;
      ring_head = '0;
      ring_live = 1'b0;
      for (int t = 0; t < SLOTS; t++) begin
         run_flag[t] = 1'b0;
         nxt_ln[t] = '0;
         prv_ln[t] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (!req_ready) @(negedge clock);

      // reset value of the idle thread, redundant clear
      push_pick(ID_W'(0), 1'b0);
      push_set(ID_W'(5), 1'b0);
      push_pick(ID_W'(63), 1'b1);
      wait_quiet();
      csr_write(CSR_DATA_W'(63));

      push_pick(ID_W'(21), 1'b0);
      push_set(ID_W'(63), 1'b1);
      push_set(ID_W'(0), 1'b1);
      push_set(ID_W'(63), 1'b1);
      push_pick(ID_W'(0), 1'b0);
      push_pick(ID_W'(0), 1'b0);
      push_pick(ID_W'(0), 1'b0);
      push_set(ID_W'(42), 1'b1);
      push_pick(ID_W'(42), 1'b1);
      push_set(ID_W'(63), 1'b0);
      push_pick(ID_W'(0), 1'b0);
      push_set(ID_W'(0), 1'b0);
      push_set(ID_W'(42), 1'b0);
      push_pick(ID_W'(0), 1'b0);
      push_set(ID_W'(21), 1'b1);
      push_pick(ID_W'(0), 1'b0);
      push_pick(ID_W'(0), 1'b0);
      push_set(ID_W'(21), 1'b0);
      push_pick(ID_W'(63), 1'b1);
      wait_quiet();

      csr_write(CSR_DATA_W'($urandom_range(1, 62)));
      sender_idle_pct = 22;
      recv_idle_pct = 78;
      gen_phase(140);
      wait_quiet();

      csr_write(CSR_DATA_W'(0));
      sender_idle_pct = 78;
      recv_idle_pct = 22;
      gen_phase(140);
      wait_quiet();

      csr_write(CSR_DATA_W'($urandom_range(63)));
      sender_idle_pct = 0;
      recv_idle_pct = 0;
      gen_phase(140);
      wait_quiet();
      repeat (20) @(negedge clock);

      $display("tb: %0d set-state and %0d pick transfers, %0d picks on an empty ring",
               n_sets, n_picks, n_idle_picks);
      $display("tb: largest ring held %0d threads, %0d results checked", max_ring,
               results_seen);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
